// ----- src/gvec_pkg.sv -----
`default_nettype none
package gvec_pkg;

  localparam int unsigned MaxVerticesDef = 16;
  localparam int unsigned MaxEdgesDef    = 32;
  localparam int unsigned CoordBitsDef   = 16;

  localparam logic [1:0] CMD_VERTEX = 2'd0;
  localparam logic [1:0] CMD_EDGE   = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  localparam logic [1:0] KIND_VERTEX = 2'd0;
  localparam logic [1:0] KIND_EDGE   = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RANGE    = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHK_RD, ST_CHK_EV,
    ST_FST_RI, ST_FST_LI, ST_FST_RJ, ST_FST_EJ,
    ST_RNK_RI, ST_RNK_LI, ST_RNK_RJ, ST_RNK_EJ, ST_RNK_WR,
    ST_MAP_RE, ST_MAP_RA, ST_MAP_RB, ST_MAP_WR,
    ST_VTX_RD, ST_VTX_EV,
    ST_EDG_RD, ST_EDG_EV, ST_EDG_END, ST_EDG_OUT
  } gvec_state_e;

endpackage
`default_nettype wire

// ----- src/graph_vertex_edge_compaction_core.sv -----
`default_nettype none
// Graph compaction core. A vertex or edge load is taken when start_i is high and busy_o is
// low; a load into a full store answers with one overflow error beat on the next cycle. A run
// command sorts and merges the vertices, remaps and deduplicates the edges and emits the kept
// vertices, then the edges, one beat per valid_o strobe, last_o on the final beat; a run with
// an empty store, or whose edges all become self-loops, answers with one empty beat, and one
// with an edge index out of range with one range error beat; the receiver cannot stall, so
// every beat must be taken when shown. Every scan goes through memories with one read port
// (two on the renumbering memory), and the edge order is found by a fresh pass over the edge
// store for each edge out.
module graph_vertex_edge_compaction_core #(
  parameter int unsigned MAX_VERTICES = gvec_pkg::MaxVerticesDef,
  parameter int unsigned MAX_EDGES    = gvec_pkg::MaxEdgesDef,
  parameter int unsigned COORD_BITS   = gvec_pkg::CoordBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] x_coord_i,
  input  wire logic [15:0] y_coord_i,
  input  wire logic [15:0] z_coord_i,
  input  wire logic [31:0] radius_word_i,
  input  wire logic [7:0]  edge_first_i,
  input  wire logic [7:0]  edge_second_i,
  output logic             valid_o,
  output logic [1:0]       kind_o,
  output logic [15:0]      out_x_o,
  output logic [15:0]      out_y_o,
  output logic [15:0]      out_z_o,
  output logic [31:0]      out_radius_o,
  output logic [3:0]       out_low_index_o,
  output logic [3:0]       out_high_index_o,
  output logic [1:0]       error_code_o,
  output logic             last_o
);
  import gvec_pkg::*;

  localparam int unsigned VW  = $clog2(MAX_VERTICES);
  localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned CW  = 3 * COORD_BITS;
  localparam int unsigned DW  = CW + 32;
  localparam int unsigned KW  = 2 * VW;

  // memories
  logic [DW-1:0] vtx_mem [MAX_VERTICES];
  logic [DW-1:0] srt_mem [MAX_VERTICES];
  logic [15:0]   edg_mem [MAX_EDGES];
  logic [VW-1:0] map_mem [MAX_VERTICES];
  logic [VW-1:0] ren_mem [MAX_VERTICES];

  logic          vtx_we, srt_we, edg_we, map_we, ren_we;
  logic [VW-1:0] vtx_wa, vtx_ra, srt_wa, srt_ra, map_wa, map_ra, ren_wa, ren_ra_a, ren_ra_b;
  logic [EAW-1:0] edg_wa, edg_ra;
  logic [DW-1:0] vtx_wd, srt_wd;
  logic [15:0]   edg_wd;
  logic [VW-1:0] map_wd, ren_wd;
  logic [DW-1:0] vtx_rd_q, srt_rd_q;
  logic [15:0]   edg_rd_q;
  logic [VW-1:0] map_rd_q, ren_rd_a_q, ren_rd_b_q;

  always_ff @(posedge clk_i) begin
    if (vtx_we) vtx_mem[vtx_wa] <= vtx_wd;
    vtx_rd_q <= vtx_mem[vtx_ra];
  end
  always_ff @(posedge clk_i) begin
    if (srt_we) srt_mem[srt_wa] <= srt_wd;
    srt_rd_q <= srt_mem[srt_ra];
  end
  always_ff @(posedge clk_i) begin
    if (edg_we) edg_mem[edg_wa] <= edg_wd;
    edg_rd_q <= edg_mem[edg_ra];
  end
  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_rd_q <= map_mem[map_ra];
  end
  always_ff @(posedge clk_i) begin
    if (ren_we) ren_mem[ren_wa] <= ren_wd;
    ren_rd_a_q <= ren_mem[ren_ra_a];
    ren_rd_b_q <= ren_mem[ren_ra_b];
  end

  // control and working registers
  gvec_state_e st_q, st_d;
  logic [VCW-1:0] vcnt_q, vcnt_d, i_q, i_d, j_q, j_d, r_q, r_d, u_q, u_d, kept_q, kept_d;
  logic [ECW-1:0] ecnt_q, ecnt_d, e_q, e_d;
  logic [VW-1:0]  rank_q, rank_d, a_q, a_d;
  logic [7:0]     eb_q, eb_d;
  logic [MAX_VERTICES-1:0] first_q, first_d, used_q, used_d;
  logic           any_q, any_d, hp_q, hp_d, hb_q, hb_d, pv_q, pv_d, plast_q, plast_d;
  logic [KW-1:0]  prev_q, prev_d, best_q, best_d, pend_q, pend_d;
  logic [DW-1:0]  cur_q, cur_d;

  logic        valid_q, valid_d, last_q, last_d;
  logic [1:0]  kind_q, kind_d, err_q, err_d;
  logic [15:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [31:0] rad_q, rad_d;
  logic [3:0]  lo_q, lo_d, hi_q, hi_d;

  logic accept;
  logic [VCW-1:0] i_nx, j_nx, r_nx;
  logic [ECW-1:0] e_nx;
  logic i_end, jf_end, jr_end, r_end, e_end, bad_edge, cand, lt_cur;
  logic [CW-1:0] v_c;
  logic [7:0] e_a, e_b;
  logic [VW-1:0] k_lo, k_hi, m_lo, m_hi;
  logic [KW-1:0] key;

  assign accept   = start_i && !busy_o;
  assign i_nx     = i_q + VCW'(1);
  assign j_nx     = j_q + VCW'(1);
  assign r_nx     = r_q + VCW'(1);
  assign e_nx     = e_q + ECW'(1);
  assign i_end    = (i_nx == vcnt_q);
  assign jf_end   = (j_nx == i_q);
  assign jr_end   = (j_nx == vcnt_q);
  assign r_end    = (r_nx == u_q);
  assign e_end    = (e_nx == ecnt_q);
  assign v_c      = vtx_rd_q[DW-1:32];
  assign lt_cur   = (v_c < cur_q[DW-1:32]);
  assign e_a      = edg_rd_q[15:8];
  assign e_b      = edg_rd_q[7:0];
  assign bad_edge = ({1'b0, e_a} >= 9'(vcnt_q)) || ({1'b0, e_b} >= 9'(vcnt_q));
  assign k_lo     = e_a[VW-1:0];
  assign k_hi     = e_b[VW-1:0];
  assign key      = {k_lo, k_hi};
  assign cand     = (k_lo != k_hi) && (!hp_q || key > prev_q) && (!hb_q || key < best_q);
  assign m_lo     = (a_q < map_rd_q) ? a_q : map_rd_q;
  assign m_hi     = (a_q < map_rd_q) ? map_rd_q : a_q;

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:
        if (accept && command_i == CMD_RUN && vcnt_q != '0 && ecnt_q != '0) st_d = ST_CHK_RD;
      ST_CHK_RD: st_d = ST_CHK_EV;
      ST_CHK_EV: begin
        if (bad_edge) st_d = ST_IDLE;
        else if (e_end) st_d = ST_FST_RI;
        else st_d = ST_CHK_RD;
      end
      ST_FST_RI: st_d = ST_FST_LI;
      ST_FST_LI: begin
        if (i_q != '0) st_d = ST_FST_RJ;
        else if (i_end) st_d = ST_RNK_RI;
        else st_d = ST_FST_RI;
      end
      ST_FST_RJ: st_d = ST_FST_EJ;
      ST_FST_EJ: begin
        if (!jf_end) st_d = ST_FST_RJ;
        else if (i_end) st_d = ST_RNK_RI;
        else st_d = ST_FST_RI;
      end
      ST_RNK_RI: st_d = ST_RNK_LI;
      ST_RNK_LI: st_d = ST_RNK_RJ;
      ST_RNK_RJ: st_d = ST_RNK_EJ;
      ST_RNK_EJ: st_d = jr_end ? ST_RNK_WR : ST_RNK_RJ;
      ST_RNK_WR: st_d = i_end ? ST_MAP_RE : ST_RNK_RI;
      ST_MAP_RE: st_d = ST_MAP_RA;
      ST_MAP_RA: st_d = ST_MAP_RB;
      ST_MAP_RB: st_d = ST_MAP_WR;
      ST_MAP_WR: begin
        if (!e_end) st_d = ST_MAP_RE;
        else if (any_q || m_lo != m_hi) st_d = ST_VTX_RD;
        else st_d = ST_IDLE;
      end
      ST_VTX_RD: st_d = ST_VTX_EV;
      ST_VTX_EV: st_d = r_end ? ST_EDG_RD : ST_VTX_RD;
      ST_EDG_RD: st_d = ST_EDG_EV;
      ST_EDG_EV: st_d = e_end ? ST_EDG_END : ST_EDG_RD;
      ST_EDG_END: st_d = (hb_q && !pv_q) ? ST_EDG_RD : ST_EDG_OUT;
      ST_EDG_OUT: st_d = plast_q ? ST_IDLE : ST_EDG_RD;
      default: st_d = ST_IDLE;
    endcase
  end

  // datapath and result beats
  always_comb begin
    vcnt_d = vcnt_q; ecnt_d = ecnt_q; i_d = i_q; j_d = j_q; r_d = r_q; u_d = u_q;
    kept_d = kept_q; e_d = e_q; rank_d = rank_q; a_d = a_q; eb_d = eb_q;
    first_d = first_q; used_d = used_q; any_d = any_q; hp_d = hp_q; hb_d = hb_q;
    pv_d = pv_q; plast_d = plast_q; prev_d = prev_q; best_d = best_q; pend_d = pend_q;
    cur_d = cur_q;
    valid_d = 1'b0; kind_d = KIND_EMPTY; err_d = ERR_NONE; last_d = 1'b0;
    x_d = '0; y_d = '0; z_d = '0; rad_d = '0; lo_d = '0; hi_d = '0;
    vtx_we = 1'b0; vtx_wa = vcnt_q[VW-1:0]; vtx_ra = i_q[VW-1:0];
    vtx_wd = {COORD_BITS'(x_coord_i), COORD_BITS'(y_coord_i), COORD_BITS'(z_coord_i),
              radius_word_i};
    srt_we = 1'b0; srt_wa = rank_q; srt_wd = cur_q; srt_ra = r_q[VW-1:0];
    edg_we = 1'b0; edg_wa = ecnt_q[EAW-1:0]; edg_wd = {edge_first_i, edge_second_i};
    edg_ra = e_q[EAW-1:0];
    map_we = 1'b0; map_wa = i_q[VW-1:0]; map_wd = rank_q; map_ra = e_a[VW-1:0];
    ren_we = 1'b0; ren_wa = r_q[VW-1:0]; ren_wd = kept_q[VW-1:0];
    ren_ra_a = pend_q[KW-1:VW]; ren_ra_b = pend_q[VW-1:0];

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (command_i)
            CMD_VERTEX: begin
              if (vcnt_q == VCW'(MAX_VERTICES)) begin
                valid_d = 1'b1; kind_d = KIND_ERROR; err_d = ERR_OVERFLOW; last_d = 1'b1;
              end else begin
                vtx_we = 1'b1; vcnt_d = vcnt_q + VCW'(1);
              end
            end
            CMD_EDGE: begin
              if (ecnt_q == ECW'(MAX_EDGES)) begin
                valid_d = 1'b1; kind_d = KIND_ERROR; err_d = ERR_OVERFLOW; last_d = 1'b1;
              end else begin
                edg_we = 1'b1; ecnt_d = ecnt_q + ECW'(1);
              end
            end
            CMD_RUN: begin
              if (vcnt_q == '0 || ecnt_q == '0) begin
                valid_d = 1'b1; kind_d = KIND_EMPTY; last_d = 1'b1;
                vcnt_d = '0; ecnt_d = '0;
              end
              e_d = '0;
            end
            default: ;
          endcase
        end
      end
      ST_CHK_RD: ;
      ST_CHK_EV: begin
        if (bad_edge) begin
          valid_d = 1'b1; kind_d = KIND_ERROR; err_d = ERR_RANGE; last_d = 1'b1;
          vcnt_d = '0; ecnt_d = '0;
        end
        e_d = e_nx;
        if (e_end) i_d = '0;
      end
      ST_FST_RI: ;
      ST_FST_LI: begin
        cur_d = vtx_rd_q; j_d = '0; first_d[i_q[VW-1:0]] = 1'b1;
        if (i_q == '0) begin
          i_d = i_nx;
          if (i_end) begin i_d = '0; u_d = '0; end
        end
      end
      ST_FST_RJ: vtx_ra = j_q[VW-1:0];
      ST_FST_EJ: begin
        if (v_c == cur_q[DW-1:32]) first_d[i_q[VW-1:0]] = 1'b0;
        j_d = j_nx;
        if (jf_end) begin
          i_d = i_nx;
          if (i_end) begin i_d = '0; u_d = '0; end
        end
      end
      ST_RNK_RI: ;
      ST_RNK_LI: begin cur_d = vtx_rd_q; j_d = '0; rank_d = '0; end
      ST_RNK_RJ: vtx_ra = j_q[VW-1:0];
      ST_RNK_EJ: begin
        if (first_q[j_q[VW-1:0]] && lt_cur) rank_d = rank_q + VW'(1);
        j_d = j_nx;
      end
      ST_RNK_WR: begin
        map_we = 1'b1;
        if (first_q[i_q[VW-1:0]]) begin srt_we = 1'b1; u_d = u_q + VCW'(1); end
        i_d = i_nx;
        if (i_end) begin e_d = '0; used_d = '0; any_d = 1'b0; end
      end
      ST_MAP_RE: ;
      ST_MAP_RA: eb_d = e_b;
      ST_MAP_RB: begin a_d = map_rd_q; map_ra = eb_q[VW-1:0]; end
      ST_MAP_WR: begin
        edg_we = 1'b1; edg_wa = e_q[EAW-1:0]; edg_wd = {8'(m_lo), 8'(m_hi)};
        if (m_lo != m_hi) begin used_d[m_lo] = 1'b1; used_d[m_hi] = 1'b1; any_d = 1'b1; end
        e_d = e_nx;
        if (e_end) begin
          r_d = '0; kept_d = '0;
          if (!(any_q || m_lo != m_hi)) begin
            valid_d = 1'b1; kind_d = KIND_EMPTY; last_d = 1'b1;
            vcnt_d = '0; ecnt_d = '0;
          end
        end
      end
      ST_VTX_RD: ;
      ST_VTX_EV: begin
        if (used_q[r_q[VW-1:0]]) begin
          valid_d = 1'b1; kind_d = KIND_VERTEX;
          x_d = 16'(srt_rd_q[32+2*COORD_BITS +: COORD_BITS]);
          y_d = 16'(srt_rd_q[32+COORD_BITS +: COORD_BITS]);
          z_d = 16'(srt_rd_q[32 +: COORD_BITS]);
          rad_d = srt_rd_q[31:0];
          ren_we = 1'b1; kept_d = kept_q + VCW'(1);
        end
        r_d = r_nx;
        if (r_end) begin e_d = '0; hp_d = 1'b0; hb_d = 1'b0; pv_d = 1'b0; end
      end
      ST_EDG_RD: ;
      ST_EDG_EV: begin
        if (cand) begin best_d = key; hb_d = 1'b1; end
        e_d = e_nx;
      end
      ST_EDG_END: begin
        // a found edge waits as pending so the final one can carry last
        plast_d = !hb_q;
        if (hb_q && !pv_q) begin
          pend_d = best_q; pv_d = 1'b1; prev_d = best_q; hp_d = 1'b1;
          hb_d = 1'b0; e_d = '0;
        end
      end
      ST_EDG_OUT: begin
        valid_d = 1'b1; kind_d = KIND_EDGE; last_d = plast_q;
        lo_d = 4'(ren_rd_a_q); hi_d = 4'(ren_rd_b_q);
        if (plast_q) begin
          vcnt_d = '0; ecnt_d = '0;
        end else begin
          pend_d = best_q; prev_d = best_q; hb_d = 1'b0; e_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      vcnt_q  <= '0;
      ecnt_q  <= '0;
      valid_q <= 1'b0;
      used_q  <= '0;
    end else begin
      st_q    <= st_d;
      vcnt_q  <= vcnt_d;
      ecnt_q  <= ecnt_d;
      valid_q <= valid_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; j_q <= j_d; r_q <= r_d; u_q <= u_d; kept_q <= kept_d; e_q <= e_d;
    rank_q <= rank_d; a_q <= a_d; eb_q <= eb_d; first_q <= first_d; any_q <= any_d;
    hp_q <= hp_d; hb_q <= hb_d; pv_q <= pv_d; plast_q <= plast_d;
    prev_q <= prev_d; best_q <= best_d; pend_q <= pend_d; cur_q <= cur_d;
    kind_q <= kind_d; err_q <= err_d; last_q <= last_d;
    x_q <= x_d; y_q <= y_d; z_q <= z_d; rad_q <= rad_d; lo_q <= lo_d; hi_q <= hi_d;
  end

  assign busy_o           = (st_q != ST_IDLE);
  assign valid_o          = valid_q;
  assign kind_o           = kind_q;
  assign out_x_o          = x_q;
  assign out_y_o          = y_q;
  assign out_z_o          = z_q;
  assign out_radius_o     = rad_q;
  assign out_low_index_o  = lo_q;
  assign out_high_index_o = hi_q;
  assign error_code_o     = err_q;
  assign last_o           = last_q;

  // a run that ends has emptied both stores
  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o && error_code_o != ERR_OVERFLOW |-> vcnt_q == '0 && ecnt_q == '0)
    else $error("stores not cleared at end of run");

  // renumbering keeps order, so edges come out strictly low first
  a_edge_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && kind_o == KIND_EDGE |-> out_low_index_o < out_high_index_o)
    else $error("edge beat not ordered low first");

  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ((kind_o == KIND_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code does not match kind");

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gvec_pkg::*;

  localparam int NumV = MaxVerticesDef;
  localparam int NumE = MaxEdgesDef;
  localparam int WatchdogLimit = 20000;
  localparam int TailCycles = 100;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [31:0] r;
    logic [7:0]  ef;
    logic [7:0]  es;
  } load_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [31:0] r;
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [1:0]  err;
    logic        last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] command_i = CMD_VERTEX;
  logic [15:0] x_coord_i = '0;
  logic [15:0] y_coord_i = '0;
  logic [15:0] z_coord_i = '0;
  logic [31:0] radius_word_i = '0;
  logic [7:0] edge_first_i = '0;
  logic [7:0] edge_second_i = '0;
  logic busy_o, valid_o, last_o;
  logic [1:0] kind_o, error_code_o;
  logic [15:0] out_x_o, out_y_o, out_z_o;
  logic [31:0] out_radius_o;
  logic [3:0] out_low_index_o, out_high_index_o;

  graph_vertex_edge_compaction_core DUT (.*);

  always #10 clk_i = ~clk_i;

  load_item_t stim_q[$];
  beat_t expected_beats[$];
  int total_items = 0;
  int accepted = 0;
  int failures = 0;
  int runs = 0, vtx_seen = 0, edg_seen = 0, err_seen = 0, empty_seen = 0;

  // shadow of the block's stores
  logic [47:0] vkey[NumV];
  logic [31:0] vrad[NumV];
  logic [7:0]  ea[NumE];
  logic [7:0]  eb[NumE];
  int vcnt = 0, ecnt = 0;

  function automatic beat_t status_beat(logic [1:0] kind, logic [1:0] err);
    beat_t b;
    b = '0;
    b.kind = kind;
    b.err = err;
    b.last = 1'b1;
    return b;
  endfunction

  function automatic void expect_beat(beat_t b);
    expected_beats = {expected_beats, b};
  endfunction

  task automatic compact_graph();
    int order[NumV];
    logic [47:0] uc[NumV];
    logic [31:0] ur[NumV];
    int imap[NumV];
    int rn[NumV];
    int pk[NumE];
    bit used[NumV];
    int i, j, u, p, kept, a, b, t, key;
    beat_t o;
    u = 0;
    p = 0;
    kept = 0;
    if (vcnt == 0 || ecnt == 0) begin
      expect_beat(status_beat(KIND_EMPTY, ERR_NONE));
      return;
    end
    for (i = 0; i < ecnt; i++) begin
      if (ea[i] >= vcnt || eb[i] >= vcnt) begin
        expect_beat(status_beat(KIND_ERROR, ERR_RANGE));
        return;
      end
    end
    // stable insertion sort on the packed x,y,z key
    for (i = 0; i < vcnt; i++) begin
      j = i;
      while (j > 0 && vkey[order[j-1]] > vkey[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < vcnt; i++) begin
      if (u == 0 || uc[u-1] != vkey[order[i]]) begin
        uc[u] = vkey[order[i]];
        ur[u] = vrad[order[i]];
        u++;
      end
      imap[order[i]] = u - 1;
    end
    for (i = 0; i < ecnt; i++) begin
      a = imap[ea[i]];
      b = imap[eb[i]];
      if (a > b) begin
        t = a; a = b; b = t;
      end
      if (a != b) begin
        key = a * 256 + b;
        j = p;
        while (j > 0 && pk[j-1] > key) begin
          pk[j] = pk[j-1];
          j--;
        end
        pk[j] = key;
        p++;
      end
    end
    if (p == 0) begin
      expect_beat(status_beat(KIND_EMPTY, ERR_NONE));
      return;
    end
    j = 0;
    for (i = 0; i < p; i++)
      if (j == 0 || pk[j-1] != pk[i]) begin
        pk[j] = pk[i];
        j++;
      end
    p = j;
    for (i = 0; i < NumV; i++) used[i] = 1'b0;
    for (i = 0; i < p; i++) begin
      used[pk[i] / 256] = 1'b1;
      used[pk[i] % 256] = 1'b1;
    end
    for (i = 0; i < u; i++) begin
      if (used[i]) begin
        rn[i] = kept;
        kept++;
        o = '0;
        o.kind = KIND_VERTEX;
        {o.x, o.y, o.z} = uc[i];
        o.r = ur[i];
        expect_beat(o);
      end
    end
    for (i = 0; i < p; i++) begin
      o = '0;
      o.kind = KIND_EDGE;
      o.lo = 4'(rn[pk[i] / 256]);
      o.hi = 4'(rn[pk[i] % 256]);
      o.last = (i == p - 1);
      expect_beat(o);
    end
  endtask

  task automatic apply_item(load_item_t it);
    case (it.cmd)
      CMD_VERTEX: begin
        if (vcnt >= NumV) expect_beat(status_beat(KIND_ERROR, ERR_OVERFLOW));
        else begin
          vkey[vcnt] = {it.x, it.y, it.z};
          vrad[vcnt] = it.r;
          vcnt++;
        end
      end
      CMD_EDGE: begin
        if (ecnt >= NumE) expect_beat(status_beat(KIND_ERROR, ERR_OVERFLOW));
        else begin
          ea[ecnt] = it.ef;
          eb[ecnt] = it.es;
          ecnt++;
        end
      end
      CMD_RUN: begin
        compact_graph();
        runs++;
        vcnt = 0;
        ecnt = 0;
      end
      default: ;
    endcase
  endtask

  // driver
  load_item_t cur;
  int gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic nxt;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        apply_item(cur);
        accepted++;
      end
      if (!(start_i && busy_o)) begin
        nxt = 1'b0;
        if (gap > 0) begin
          gap--;
        end else if (stim_q.size() > 0 && accepted < total_items - 40 &&
                     $urandom_range(0, 7) == 0) begin
          gap = $urandom_range(1, 7) - 1;
        end else if (stim_q.size() > 0) begin
          cur = stim_q.pop_front();
          command_i <= cur.cmd;
          x_coord_i <= cur.x;
          y_coord_i <= cur.y;
          z_coord_i <= cur.z;
          radius_word_i <= cur.r;
          edge_first_i <= cur.ef;
          edge_second_i <= cur.es;
          nxt = 1'b1;
        end
        start_i <= nxt;
      end
    end
  end

  // monitor and watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    beat_t act, exp_b;
    if (rst_ni) begin
      if (valid_o || (start_i && !busy_o)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no activity for %0d cycles", $realtime, WatchdogLimit);
        $display("Verification failed");
        $finish;
      end
      if (valid_o) begin
        act = {kind_o, out_x_o, out_y_o, out_z_o, out_radius_o, out_low_index_o,
               out_high_index_o, error_code_o, last_o};
        case (kind_o)
          KIND_VERTEX: vtx_seen++;
          KIND_EDGE:   edg_seen++;
          KIND_EMPTY:  empty_seen++;
          default:     err_seen++;
        endcase
        if (expected_beats.size() == 0) begin
          failures++;
          $display("%0t: unexpected beat, expected none, actual %h", $realtime, act);
        end else begin
          exp_b = expected_beats.pop_front();
          if (act !== exp_b) begin
            failures++;
            $display({"%0t: mismatch expected kind=%0d x=%h y=%h z=%h r=%h",
                      " lo=%0d hi=%0d err=%0d last=%0d"},
                     $realtime, exp_b.kind, exp_b.x, exp_b.y, exp_b.z, exp_b.r, exp_b.lo,
                     exp_b.hi, exp_b.err, exp_b.last);
            $display({"%0t:          actual   kind=%0d x=%h y=%h z=%h r=%h",
                      " lo=%0d hi=%0d err=%0d last=%0d"},
                     $realtime, act.kind, act.x, act.y, act.z, act.r, act.lo, act.hi,
                     act.err, act.last);
          end
        end
      end
    end
  end

  task automatic add_item(logic [1:0] cmd, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                          logic [31:0] r, logic [7:0] ef, logic [7:0] es);
    load_item_t it;
    it = {cmd, x, y, z, r, ef, es};
    stim_q = {stim_q, it};
    total_items++;
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_vertex_rand();
    add_item(CMD_VERTEX, pick_coord(), pick_coord(), pick_coord(), $urandom,
             8'($urandom), 8'($urandom));
  endtask

  task automatic add_edge_ix(logic [7:0] a, logic [7:0] b);
    add_item(CMD_EDGE, 16'($urandom), 16'($urandom), 16'($urandom), $urandom, a, b);
  endtask

  task automatic add_run();
    add_item(CMD_RUN, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
             8'($urandom), 8'($urandom));
  endtask

  initial begin
    int nv, ne, live, k;
    bit bad;
    // directed: ignored command, empty run, merge and dedup, self-loops, range error
    add_item(2'd3, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 8'hff, 8'hff);
    add_run();
    add_item(CMD_VERTEX, 16'h0000, 16'h0000, 16'h0000, 32'h00000000, 8'h00, 8'h00);
    add_item(CMD_VERTEX, 16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 8'hff, 8'hff);
    add_item(CMD_VERTEX, 16'h0000, 16'h0000, 16'h0000, 32'hffffffff, 8'h00, 8'h00);
    add_item(CMD_VERTEX, 16'h0001, 16'h0000, 16'hffff, 32'h12345678, 8'h00, 8'h00);
    add_edge_ix(8'd0, 8'd1);
    add_edge_ix(8'd2, 8'd1);
    add_edge_ix(8'd0, 8'd2);
    add_edge_ix(8'd3, 8'd3);
    add_edge_ix(8'd3, 8'd1);
    add_run();
    add_item(CMD_VERTEX, 16'h0005, 16'h0006, 16'h0007, 32'h0badf00d, 8'h00, 8'h00);
    add_run();
    add_edge_ix(8'd0, 8'd0);
    add_run();
    add_item(CMD_VERTEX, 16'h00aa, 16'h0001, 16'h0002, 32'h11111111, 8'h00, 8'h00);
    add_item(CMD_VERTEX, 16'h00aa, 16'h0001, 16'h0002, 32'h22222222, 8'h00, 8'h00);
    add_edge_ix(8'd1, 8'd0);
    add_run();
    add_item(CMD_VERTEX, 16'h0100, 16'h0200, 16'h0300, 32'h5a5a5a5a, 8'h00, 8'h00);
    add_edge_ix(8'd0, 8'd5);
    add_edge_ix(8'hff, 8'd0);
    add_run();
    // random graphs, some overflowing the stores, some with bad indices
    while (total_items < 250) begin
      case ($urandom_range(0, 9))
        0: nv = $urandom_range(16, 18);
        1: nv = 0;
        default: nv = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 9))
        0: ne = $urandom_range(31, 34);
        1: ne = 0;
        default: ne = $urandom_range(1, 10);
      endcase
      live = (nv > NumV) ? NumV : nv;
      bad = ($urandom_range(0, 6) == 0);
      for (k = 0; k < nv; k++) add_vertex_rand();
      for (k = 0; k < ne; k++) begin
        if (live == 0 || (bad && $urandom_range(0, 3) == 0))
          add_edge_ix(8'($urandom), 8'($urandom));
        else
          add_edge_ix(8'($urandom_range(0, live - 1)), 8'($urandom_range(0, live - 1)));
        if ($urandom_range(0, 19) == 0) begin
          add_item(2'd3, 16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                   8'($urandom), 8'($urandom));
          total_items--;
        end
      end
      add_run();
    end
    total_items = stim_q.size();

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (stim_q.size() > 0 || start_i || expected_beats.size() > 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    $display("covered %0d loads and runs over %0d runs", accepted, runs);
    $display("saw %0d vertex, %0d edge, %0d empty and %0d error beats",
             vtx_seen, edg_seen, empty_seen, err_seen);
    if (failures == 0 && expected_beats.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
